// File: hw/rtl/itar_pkg.sv
// Package for the radix conversion block: widths, character codes and the
// request/response types exchanged with the serial divider.
// Depends on nothing; every other file in hw/rtl uses it.
`default_nettype none

package itar_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;
    localparam int DIGIT_BITS = 5;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);

    localparam logic [RADIX_BITS-1:0] MIN_RADIX     = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] MAX_RADIX     = RADIX_BITS'(32);
    localparam logic [RADIX_BITS-1:0] DECIMAL_RADIX = RADIX_BITS'(10);

    localparam logic [CHAR_BITS-1:0] DIGIT_BASE_CHAR = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0] LETTER_OFFSET   = CHAR_BITS'(65 - 10);
    localparam logic [CHAR_BITS-1:0] MINUS_CHAR      = CHAR_BITS'(45);
    localparam logic [CHAR_BITS-1:0] ERROR_CHAR      = CHAR_BITS'(0);

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_BITS-1:0] remainder;
    } div_rsp_t;

    function automatic logic [CHAR_BITS-1:0] digit_to_char(
        input logic [DIGIT_BITS-1:0] digit
    );
        logic [CHAR_BITS-1:0] wide;
        wide = CHAR_BITS'(digit);
        if (digit >= DIGIT_BITS'(10))
        begin
            return LETTER_OFFSET + wide;
        end
        return DIGIT_BASE_CHAR + wide;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itar_in_if.sv
// Input channel: a signed value and a radix under a valid/ready handshake.
// Depends on itar_pkg for the field widths.
`default_nettype none

interface itar_in_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [itar_pkg::VALUE_BITS-1:0] value;
    logic        [itar_pkg::RADIX_BITS-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);

endinterface

`default_nettype wire

// File: hw/rtl/itar_out_if.sv
// Output channel: one ASCII character per transfer with last and error flags.
// Depends on itar_pkg for the field widths.
`default_nettype none

interface itar_out_if;

    logic                             valid;
    logic                             ready;
    logic [itar_pkg::CHAR_BITS-1:0]   digit_char;
    logic                             last;
    logic                             bad_radix;

    modport source (output valid, output digit_char, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input digit_char, input last, input bad_radix,
                    output ready);

endinterface

`default_nettype wire

// File: hw/rtl/itar_divider.sv
// Restoring divider that produces one quotient bit per cycle by shifting the
// dividend through a register. Depends on itar_pkg for widths and types.
`default_nettype none

module itar_divider (
    input  wire                  clk,
    input  wire                  rst_n,
    input  itar_pkg::div_req_t   req,
    output itar_pkg::div_rsp_t   rsp
);

    logic [itar_pkg::VALUE_BITS-1:0] quo_reg;
    logic [itar_pkg::VALUE_BITS-1:0] quo_next;
    logic [itar_pkg::DIGIT_BITS-1:0] rem_reg;
    logic [itar_pkg::DIGIT_BITS-1:0] rem_next;
    logic [itar_pkg::RADIX_BITS-1:0] dvs_reg;
    logic [itar_pkg::CNT_W-1:0]      cnt_reg;
    logic [itar_pkg::CNT_W-1:0]      cnt_next;
    logic                            busy_reg;
    logic                            busy_next;
    logic                            done_reg;
    logic                            done_next;
    logic [itar_pkg::RADIX_BITS-1:0] trial;
    logic [itar_pkg::RADIX_BITS-1:0] diff;

    // The partial remainder stays below the divisor, so it fits in five bits.
    assign trial = {rem_reg, quo_reg[itar_pkg::VALUE_BITS-1]};
    assign diff  = trial - dvs_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = itar_pkg::CNT_W'(itar_pkg::VALUE_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= dvs_reg)
            begin
                rem_next = diff[itar_pkg::DIGIT_BITS-1:0];
                quo_next = {quo_reg[itar_pkg::VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[itar_pkg::DIGIT_BITS-1:0];
                quo_next = {quo_reg[itar_pkg::VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - itar_pkg::CNT_W'(1);
            if (cnt_reg == itar_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// File: hw/rtl/itar_digit_stack.sv
// Stack of digit values, written least significant first and read back in
// reverse order. Depends on itar_pkg for widths.
`default_nettype none

module itar_digit_stack (
    input  wire                               clk,
    input  wire                               wr_en,
    input  wire [itar_pkg::IDX_W-1:0]         wr_idx,
    input  wire [itar_pkg::DIGIT_BITS-1:0]    wr_digit,
    input  wire [itar_pkg::IDX_W-1:0]         rd_idx,
    output logic [itar_pkg::CHAR_BITS-1:0]    rd_char
);

    logic [itar_pkg::DIGIT_BITS-1:0] digit_reg [itar_pkg::VALUE_BITS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_reg[wr_idx] <= wr_digit;
        end
    end

    assign rd_char = itar_pkg::digit_to_char(digit_reg[rd_idx]);

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_ascii_radix.sv
// Top level of the integer to ASCII radix converter: sequencer, sign handling
// and output register. Depends on itar_pkg, both channel interfaces,
// itar_divider and itar_digit_stack.
//
//   Channel  Role    Payload                          Handshake
//   item     sink    value, radix                     valid/ready
//   result   source  digit_char, last, bad_radix      valid/ready
//
// Each digit takes a full pass of the bit-serial divider; the characters are then
// delivered one by one through the output register. A new request is taken
// only while no conversion is under way, but the last character may still
// wait in the output register. Output stalls hold the sign, error and emit
// states, while the divide phase goes on. Reset clears the control state only.
`default_nettype none

module integer_to_ascii_radix (
    input  wire         clk,
    input  wire         rst_n,
    itar_in_if.sink     item,
    itar_out_if.source  result
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ERR  = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [itar_pkg::CNT_W-1:0]       count_reg;
    logic [itar_pkg::CNT_W-1:0]       count_next;
    logic [itar_pkg::RADIX_BITS-1:0]  radix_reg;
    logic                             sign_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [itar_pkg::CHAR_BITS-1:0]   char_reg;
    logic [itar_pkg::CHAR_BITS-1:0]   char_next;
    logic                             last_reg;
    logic                             last_next;
    logic                             bad_reg;
    logic                             bad_next;

    logic                             accept;
    logic                             out_free;
    logic                             radix_bad;
    logic [itar_pkg::VALUE_BITS-1:0]  magnitude;
    logic [itar_pkg::CNT_W-1:0]       count_dec;
    logic [itar_pkg::CHAR_BITS-1:0]   stack_char;
    logic                             push;
    itar_pkg::div_req_t               div_req;
    itar_pkg::div_rsp_t               div_rsp;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign radix_bad  = (item.radix < itar_pkg::MIN_RADIX)
                     || (item.radix > itar_pkg::MAX_RADIX);
    assign magnitude  = item.value[itar_pkg::VALUE_BITS-1]
                      ? (~item.value + itar_pkg::VALUE_BITS'(1))
                      : item.value;
    assign count_dec  = count_reg - itar_pkg::CNT_W'(1);
    assign push       = (state_reg == ST_DIV) && div_rsp.done;

    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = div_rsp.quotient;
        div_req.divisor  = radix_reg;
        if (accept && !radix_bad)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = magnitude;
            div_req.divisor  = item.radix;
        end
        else if (push && (div_rsp.quotient != '0))
        begin
            div_req.start = 1'b1;
        end
    end

    itar_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    itar_digit_stack u_stack (
        .clk      (clk),
        .wr_en    (push),
        .wr_idx   (count_reg[itar_pkg::IDX_W-1:0]),
        .wr_digit (div_rsp.remainder),
        .rd_idx   (count_dec[itar_pkg::IDX_W-1:0]),
        .rd_char  (stack_char)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !result.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = '0;
                    state_next = radix_bad ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    count_next = count_reg + itar_pkg::CNT_W'(1);
                    if (div_rsp.quotient == '0)
                    begin
                        state_next = sign_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itar_pkg::ERROR_CHAR;
                    last_next      = 1'b1;
                    bad_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = itar_pkg::MINUS_CHAR;
                    last_next      = 1'b0;
                    bad_next       = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = stack_char;
                    last_next      = (count_reg == itar_pkg::CNT_W'(1));
                    bad_next       = 1'b0;
                    count_next     = count_dec;
                    if (count_reg == itar_pkg::CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
        if (accept)
        begin
            radix_reg <= item.radix;
            sign_reg  <= item.value[itar_pkg::VALUE_BITS-1]
                      && (item.radix == itar_pkg::DECIMAL_RADIX);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.digit_char = char_reg;
    assign result.last       = last_reg;
    assign result.bad_radix  = bad_reg;

endmodule

`default_nettype wire
